// ===== rtl/core/lips_pkg.sv =====
// ----------------------------------------------------------------------------
// lips_pkg
// Shared types and codes for the lowest-index piece selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lips_pkg;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] peer_slot;
    logic       peer_named;
    logic [9:0] piece_index;
  } item_t;

  typedef struct packed {
    logic       piece_found;
    logic [9:0] chosen_piece;
    logic [1:0] status;
    logic [4:0] active_peers;
  } result_t;

  typedef enum logic [2:0] {
    CMD_ADD_PEER    = 3'd0,
    CMD_REMOVE_PEER = 3'd1,
    CMD_PEER_HAS    = 3'd2,
    CMD_WE_HAVE     = 3'd3,
    CMD_GIVE_BACK   = 3'd4,
    CMD_POLL        = 3'd5
  } command_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_PEER = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SPLIT,
    ST_RD,
    ST_MOD,
    ST_EVAL,
    ST_WIPE
  } state_t;

  localparam logic       REG_PIECE_COUNT   = 1'b0;
  localparam logic [10:0] PIECE_COUNT_RESET = 11'd1024;

endpackage

`default_nettype wire

// ===== rtl/core/lowest_index_piece_selector_core.sv =====
// ----------------------------------------------------------------------------
// lowest_index_piece_selector_core
// Per-peer candidate bitmaps and a global taken bitmap in word memories,
// walked one word at a time by a single sequencer.
// ----------------------------------------------------------------------------
// Steps: piece commands go DECODE, SPLIT, RD, MOD; peer add/remove and
//   rejects end in DECODE; WIPE clears a new peer's words; poll loops RD/EVAL.
// Throughput: one command at a time; busy is high until the result beat.
// The result beat is a one-cycle done strobe; the receiver cannot stall.
// Reset runs a clear pass over the taken bitmap, one word per cycle,
//   with busy high.
`default_nettype none

module lowest_index_piece_selector_core
  import lips_pkg::*;
#(
  parameter int PEER_SLOTS = 16,
  parameter int MAX_PIECES = 1024,
  parameter int WORD_BITS  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             done,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int WORDS = (MAX_PIECES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CAW   = $clog2(PEER_SLOTS * WORDS);
  localparam int SW    = $clog2(PEER_SLOTS);
  localparam int PTW   = $clog2(PEER_SLOTS + 1);
  localparam int BIW   = $clog2(WORD_BITS);
  localparam int RS    = 17;
  localparam int RECIP = (2 ** RS + WORD_BITS - 1) / WORD_BITS;
  localparam int PW    = RS + 10;

  state_t                 state, state_next;
  item_t                  item_q;
  logic [WAW-1:0]         w, w_next;
  logic [11:0]            base, base_next;
  logic [BIW-1:0]         bitpos, bitpos_next;
  logic [PEER_SLOTS-1:0]  peer_active, peer_active_next;
  logic [PTW-1:0]         peer_total, peer_total_next;
  logic [10:0]            piece_count;
  logic                   done_next;
  result_t                result_next;

  logic [WORD_BITS-1:0]   cand_mem [PEER_SLOTS*WORDS];
  logic [WORD_BITS-1:0]   taken_mem [WORDS];
  logic [WORD_BITS-1:0]   cand_q, taken_q;
  logic                   cand_we, taken_we;
  logic [WORD_BITS-1:0]   cand_wdata, taken_wdata;
  logic [CAW-1:0]         cand_addr;

  logic [10:0]            lim;
  logic                   in_range, slot_ok, active;
  logic [7:0]             slot_ext;
  logic [SW-1:0]          slot_idx;
  logic [PW-1:0]          prod;
  logic [15:0]            q16, rem16;
  logic [11:0]            span;
  logic [WORD_BITS-1:0]   mask, cand_m, hit, low, le, bm;
  logic [BIW-1:0]         j_idx;
  logic                   fin;
  logic                   fin_found;
  logic [9:0]             fin_chosen;
  status_t                fin_status;

  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PIECE_COUNT) ? 32'(piece_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_count <= PIECE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_PIECE_COUNT) begin
      piece_count <= pwdata[10:0];
    end
  end

  assign lim      = (32'(piece_count) > MAX_PIECES) ? 11'(MAX_PIECES) : piece_count;
  assign in_range = {1'b0, item_q.piece_index} < lim;
  assign slot_ext = 8'(item_q.peer_slot);
  assign slot_ok  = 32'(slot_ext) < PEER_SLOTS;
  assign slot_idx = slot_ext[SW-1:0];
  assign active   = slot_ok && peer_active[slot_idx];
  assign cand_addr = CAW'(slot_idx) * CAW'(WORDS) + CAW'(w);

  assign prod  = PW'(item_q.piece_index) * PW'(RECIP);
  assign q16   = 16'(prod >> RS);
  assign rem16 = 16'(item_q.piece_index) - 16'(w) * 16'(WORD_BITS);
  assign span  = 12'(lim) - base;
  assign bm    = WORD_BITS'(1) << bitpos;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = 12'(j) < span;
    end
    cand_m = cand_q & mask;
    hit    = cand_m & ~taken_q;
    j_idx  = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        j_idx = BIW'(j);
      end
    end
    low = WORD_BITS'(1) << j_idx;
    le  = (low << 1) - WORD_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_mem[cand_addr] <= cand_wdata;
    end
    if (state == ST_RD) begin
      cand_q <= cand_mem[cand_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (taken_we) begin
      taken_mem[w] <= taken_wdata;
    end
    if (state == ST_RD) begin
      taken_q <= taken_mem[w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      w           <= '0;
      peer_active <= '0;
      peer_total  <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      w           <= w_next;
      peer_active <= peer_active_next;
      peer_total  <= peer_total_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    base   <= base_next;
    bitpos <= bitpos_next;
    result <= result_next;
    if (start && !busy) begin
      item_q <= item;
    end
  end

  always_comb begin
    state_next       = state;
    w_next           = w;
    base_next        = base;
    bitpos_next      = bitpos;
    peer_active_next = peer_active;
    peer_total_next  = peer_total;
    done_next        = 1'b0;
    result_next      = result;
    cand_we          = 1'b0;
    cand_wdata       = '0;
    taken_we         = 1'b0;
    taken_wdata      = '0;
    fin              = 1'b0;
    fin_found        = 1'b0;
    fin_chosen       = '0;
    fin_status       = STAT_OK;

    unique case (state)
      ST_INIT: begin
        taken_we = 1'b1;
        if (w == WAW'(WORDS - 1)) begin
          w_next     = '0;
          state_next = ST_IDLE;
        end else begin
          w_next = w + WAW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (item_q.command)
          CMD_ADD_PEER: begin
            if (slot_ok && !active) begin
              peer_active_next[slot_idx] = 1'b1;
              peer_total_next            = peer_total + PTW'(1);
              w_next                     = '0;
              state_next                 = ST_WIPE;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_REMOVE_PEER: begin
            fin = 1'b1;
            if (active) begin
              peer_active_next[slot_idx] = 1'b0;
              peer_total_next            = peer_total - PTW'(1);
            end else begin
              fin_status = STAT_NO_PEER;
            end
          end
          CMD_PEER_HAS: begin
            if (!in_range) begin
              fin        = 1'b1;
              fin_status = STAT_RANGE;
            end else if (!active) begin
              fin        = 1'b1;
              fin_status = STAT_NO_PEER;
            end else begin
              w_next     = q16[WAW-1:0];
              state_next = ST_SPLIT;
            end
          end
          CMD_WE_HAVE, CMD_GIVE_BACK: begin
            if (!in_range) begin
              fin        = 1'b1;
              fin_status = STAT_RANGE;
            end else begin
              w_next     = q16[WAW-1:0];
              state_next = ST_SPLIT;
            end
          end
          CMD_POLL: begin
            if (!active) begin
              fin        = 1'b1;
              fin_status = STAT_NO_PEER;
            end else if (lim == 11'd0) begin
              fin = 1'b1;
            end else begin
              w_next     = '0;
              base_next  = '0;
              state_next = ST_RD;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_SPLIT: begin
        bitpos_next = rem16[BIW-1:0];
        state_next  = ST_RD;
      end
      ST_RD: begin
        state_next = (item_q.command == CMD_POLL) ? ST_EVAL : ST_MOD;
      end
      ST_MOD: begin
        fin = 1'b1;
        unique case (item_q.command)
          CMD_PEER_HAS: begin
            if (!taken_q[bitpos]) begin
              cand_we    = 1'b1;
              cand_wdata = cand_q | bm;
            end
          end
          CMD_WE_HAVE: begin
            taken_we    = 1'b1;
            taken_wdata = taken_q | bm;
          end
          CMD_GIVE_BACK: begin
            taken_we    = 1'b1;
            taken_wdata = taken_q & ~bm;
            if (item_q.peer_named) begin
              if (active) begin
                cand_we    = 1'b1;
                cand_wdata = cand_q | bm;
              end else begin
                fin_status = STAT_NO_PEER;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_EVAL: begin
        cand_we = 1'b1;
        if (|hit) begin
          cand_wdata  = cand_q & ~(cand_m & le);
          taken_we    = 1'b1;
          taken_wdata = taken_q | low;
          fin         = 1'b1;
          fin_found   = 1'b1;
          fin_chosen  = 10'(base + 12'(j_idx));
        end else begin
          cand_wdata = cand_q & ~cand_m;
          base_next  = base + 12'(WORD_BITS);
          w_next     = w + WAW'(1);
          if (base_next >= 12'(lim)) begin
            fin = 1'b1;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_WIPE: begin
        cand_we = 1'b1;
        if (w == WAW'(WORDS - 1)) begin
          fin = 1'b1;
        end else begin
          w_next = w + WAW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_next               = ST_IDLE;
      done_next                = 1'b1;
      result_next.piece_found  = fin_found;
      result_next.chosen_piece = fin_chosen;
      result_next.status       = fin_status;
      result_next.active_peers = 5'(peer_total_next);
    end
  end

endmodule

`default_nettype wire
